@@ src/scl_pkg.sv @@
// Package with the parser phase type, character codes and helper functions.
`default_nettype none

package scl_pkg;

    typedef enum logic [3:0] {
        PH_P0       = 4'd0,
        PH_P1       = 4'd1,
        PH_P2       = 4'd2,
        PH_P3       = 4'd3,
        PH_P4       = 4'd4,
        PH_P5       = 4'd5,
        PH_P6       = 4'd6,
        PH_NUM1_PRE = 4'd7,
        PH_NUM1     = 4'd8,
        PH_NUM2_PRE = 4'd9,
        PH_NUM2     = 4'd10,
        PH_NUM3_PRE = 4'd11,
        PH_NUM3     = 4'd12,
        PH_DONE     = 4'd13,
        PH_FAIL     = 4'd14
    } t_phase;

    localparam logic [7:0]  CH_LF    = 8'h0A;
    localparam logic [7:0]  CH_TAB   = 8'h09;
    localparam logic [7:0]  CH_CR    = 8'h0D;
    localparam logic [7:0]  CH_SPACE = 8'h20;
    localparam logic [7:0]  CH_PLUS  = 8'h2B;
    localparam logic [7:0]  CH_MINUS = 8'h2D;
    localparam logic [7:0]  CH_COMMA = 8'h2C;
    localparam logic [7:0]  CH_ZERO  = 8'h30;
    localparam logic [7:0]  CH_NINE  = 8'h39;

    localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
    localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;

    // Characters of the command prefix "SPEEDS:".
    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h53;
            3'd1:    ch = 8'h50;
            3'd2:    ch = 8'h45;
            3'd3:    ch = 8'h45;
            3'd4:    ch = 8'h44;
            3'd5:    ch = 8'h53;
            3'd6:    ch = 8'h3A;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Two's complement bits of a parsed number, positive side saturated.
    function automatic logic [31:0] num_bits(input logic [31:0] mag, input logic neg);
        logic [31:0] bits;
        if (neg) begin
            bits = 32'd0 - mag;
        end else if (mag[31]) begin
            bits = POS_MAX;
        end else begin
            bits = mag;
        end
        return bits;
    endfunction

endpackage

`default_nettype wire

@@ src/speed_command_line_parser_unit.sv @@
// Top level of the speed command line parser.
//
// Input stream: one received serial byte per transaction on i_s_axis_tdata.
// Bytes are gathered into lines that end at a newline byte or when a line
// reaches MAX_LINE-1 bytes. Each line is matched on the fly against
// "SPEEDS:<int>,<int>,<int>"; on a match the three stored speeds are replaced.
// Output stream: exactly one transaction per finished line, carrying the
// accepted and line-cut flags in tuser and the three stored speeds in tdata.
// Result: the output is registered and becomes valid in the cycle after the line-ending byte is taken.
// Throughput: one byte per cycle while the output register is free or draining;
// the per-byte work is a multiply-by-ten accumulate and a phase update.
// The output register holds one result. While it is full and the receiver
// holds tready low, the input tready goes low; a byte is still taken in the
// same cycle the pending result is drained.
// Reset (synchronous, active low) clears the parser, empties the output
// register and sets all stored speeds to zero.
`default_nettype none

module speed_command_line_parser_unit
    import scl_pkg::*;
#(
    parameter int MAX_LINE = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [95:0] o_m_axis_tdata,   // [31:0] speed_one, [63:32] speed_two,
                                          // [95:64] speed_three
    output logic [1:0]  o_m_axis_tuser    // [0] accepted, [1] line_cut
);

    localparam int LEN_W = $clog2(MAX_LINE);
    localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(MAX_LINE - 2);

    t_phase            r_phase, n_phase;
    logic [LEN_W-1:0]  r_len;
    logic [31:0]       r_num, n_num;
    logic              r_neg, n_neg;
    logic              r_has, n_has;
    logic [31:0]       r_first, n_first;
    logic [31:0]       r_second, n_second;
    logic [31:0]       r_speed0, r_speed1, r_speed2;
    logic              r_out_valid;
    logic              r_out_accepted;
    logic              r_out_cut;

    logic [7:0]  c;
    logic        take;
    logic        is_digit;
    logic        is_space;
    logic        is_sign;
    logic        is_lf;
    logic        line_end;
    logic        line_ok;
    logic [35:0] mul10;
    logic [35:0] acc;
    logic [31:0] acc_sat;

    assign c        = i_s_axis_tdata;
    assign take     = i_s_axis_tvalid && o_s_axis_tready;
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    assign is_sign  = (c == CH_PLUS) || (c == CH_MINUS);
    assign is_lf    = (c == CH_LF);

    // Next magnitude: value * 10 + digit, saturated to 2^31.
    assign mul10   = {1'b0, r_num, 3'b000} + {3'b000, r_num, 1'b0};
    assign acc     = mul10 + {32'd0, c[3:0]};
    assign acc_sat = (acc > {4'd0, MAG_LIMIT}) ? MAG_LIMIT : acc[31:0];

    // Phase transitions for one received byte.
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase) inside
            PH_P0, PH_P1, PH_P2, PH_P3, PH_P4, PH_P5, PH_P6: begin
                n_phase = (c == prefix_char(r_phase[2:0])) ? t_phase'(r_phase + 4'd1)
                                                           : PH_FAIL;
            end
            PH_NUM1_PRE, PH_NUM2_PRE, PH_NUM3_PRE: begin
                if (is_space) begin
                    n_phase = r_phase;
                end else if (is_sign || is_digit) begin
                    n_phase = t_phase'(r_phase + 4'd1);
                end else begin
                    n_phase = PH_FAIL;
                end
            end
            PH_NUM1, PH_NUM2, PH_NUM3: begin
                if (is_digit) begin
                    n_phase = r_phase;
                end else if (!r_has) begin
                    n_phase = PH_FAIL;
                end else if (r_phase == PH_NUM3) begin
                    n_phase = PH_DONE;
                end else if (c == CH_COMMA) begin
                    n_phase = t_phase'(r_phase + 4'd1);
                end else begin
                    n_phase = PH_FAIL;
                end
            end
            PH_DONE, PH_FAIL: begin
                n_phase = r_phase;
            end
            default: begin
                n_phase = PH_FAIL;
            end
        endcase
    end

    // Number and captured-value updates for one received byte.
    always_comb begin
        n_num    = r_num;
        n_neg    = r_neg;
        n_has    = r_has;
        n_first  = r_first;
        n_second = r_second;
        unique case (r_phase) inside
            PH_NUM1_PRE, PH_NUM2_PRE, PH_NUM3_PRE: begin
                if (!is_space) begin
                    n_num = 32'd0;
                    n_neg = (c == CH_MINUS);
                    n_has = 1'b0;
                    if (is_digit) begin
                        n_num = {28'd0, c[3:0]};
                        n_has = 1'b1;
                    end
                end
            end
            PH_NUM1, PH_NUM2: begin
                if (is_digit) begin
                    n_num = acc_sat;
                    n_has = 1'b1;
                end else if (r_has && (c == CH_COMMA)) begin
                    if (r_phase == PH_NUM1) begin
                        n_first = num_bits(r_num, r_neg);
                    end else begin
                        n_second = num_bits(r_num, r_neg);
                    end
                end
            end
            PH_NUM3: begin
                if (is_digit) begin
                    n_num = acc_sat;
                    n_has = 1'b1;
                end
            end
            default: begin
                n_num = r_num;
            end
        endcase
    end

    assign line_end = take && (is_lf || (r_len == LEN_LAST));
    assign line_ok  = (n_phase == PH_DONE) || ((n_phase == PH_NUM3) && n_has);

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_P0;
            r_len          <= '0;
            r_num          <= 32'd0;
            r_neg          <= 1'b0;
            r_has          <= 1'b0;
            r_first        <= 32'd0;
            r_second       <= 32'd0;
            r_speed0       <= 32'd0;
            r_speed1       <= 32'd0;
            r_speed2       <= 32'd0;
            r_out_valid    <= 1'b0;
            r_out_accepted <= 1'b0;
            r_out_cut      <= 1'b0;
        end else begin
            if (line_end) begin
                r_phase        <= PH_P0;
                r_len          <= '0;
                r_num          <= 32'd0;
                r_neg          <= 1'b0;
                r_has          <= 1'b0;
                r_first        <= 32'd0;
                r_second       <= 32'd0;
                r_out_valid    <= 1'b1;
                r_out_accepted <= line_ok;
                r_out_cut      <= !is_lf;
                if (line_ok) begin
                    r_speed0 <= n_first;
                    r_speed1 <= n_second;
                    r_speed2 <= num_bits(n_num, n_neg);
                end
            end else begin
                if (take) begin
                    r_phase  <= n_phase;
                    r_len    <= r_len + 1'b1;
                    r_num    <= n_num;
                    r_neg    <= n_neg;
                    r_has    <= n_has;
                    r_first  <= n_first;
                    r_second <= n_second;
                end
                if (i_m_axis_tready) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    // Stored speeds change only at a line end, which only happens while the
    // output slot is free or draining, so they can feed tdata directly.
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_speed2, r_speed1, r_speed0};
    assign o_m_axis_tuser  = {r_out_cut, r_out_accepted};

`ifndef ASSERT_OFF
    a_parser_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(line_end) |-> (r_phase == PH_P0) && (r_len == '0))
        else $error("parser state not cleared after a line end");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_LAST)
        else $error("line length passed the cut limit");

    a_mag_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_num <= MAG_LIMIT)
        else $error("number magnitude above saturation limit");

    a_speeds_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$past(line_end && line_ok)
            |-> $stable(r_speed0) && $stable(r_speed1) && $stable(r_speed2))
        else $error("stored speeds changed without an accepted line");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid)
        else $error("input stalled while output register empty");
`endif

endmodule

`default_nettype wire
